[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Both sample on i_clk and stay quiet
// while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mme_pkg.sv]
// ----------------------------------------------------------------------------
// mme_pkg
// Types and constants of the table-driven Moore machine engine.
// ----------------------------------------------------------------------------
package mme_pkg;

    localparam int CMD_W        = 3;
    localparam int STATE_FLD_W  = 4;
    localparam int SLOT_FLD_W   = 3;
    localparam int VALUE_W      = 8;
    localparam int SYMBOL_W     = 8;
    localparam int OUT_VALUE_W  = 4;
    localparam int OUT_CHAR_W   = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 4;

    localparam logic [OUT_CHAR_W-1:0] ASCII_ZERO = 8'd48;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_SYM  = 3'd0,
        CMD_LOAD_NEXT = 3'd1,
        CMD_LOAD_OUT  = 3'd2,
        CMD_FEED      = 3'd3,
        CMD_END_WORD  = 3'd4
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYMBOL_COUNT = 2'd0,
        CFG_START_STATE  = 2'd1
    } t_cfg_idx;

    localparam logic [CFG_DATA_W-1:0] SYMBOL_COUNT_RST = 4'd8;
    localparam logic [CFG_DATA_W-1:0] START_STATE_RST  = 4'd0;

endpackage

[rtl/mme_channels.sv]
// ----------------------------------------------------------------------------
// mme channels
// Valid/ready channels of the engine: command items, result items and
// configuration writes.
// ----------------------------------------------------------------------------
interface mme_in_if;
    import mme_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       cmd;
    logic [STATE_FLD_W-1:0] entry_state;
    logic [SLOT_FLD_W-1:0]  entry_slot;
    logic [VALUE_W-1:0]     entry_value;
    logic [SYMBOL_W-1:0]    symbol;

    modport source (output valid, cmd, entry_state, entry_slot, entry_value, symbol,
                    input ready);
    modport sink   (input valid, cmd, entry_state, entry_slot, entry_value, symbol,
                    output ready);
endinterface

interface mme_out_if;
    import mme_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OUT_VALUE_W-1:0] out_value;
    logic [OUT_CHAR_W-1:0]  out_char;
    logic                   word_last;

    modport source (output valid, out_value, out_char, word_last, input ready);
    modport sink   (input valid, out_value, out_char, word_last, output ready);
endinterface

interface mme_cfg_if;
    import mme_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/mme_match.sv]
// ----------------------------------------------------------------------------
// mme_match
// Alphabet code registers and a parallel compare that finds the lowest
// active slot whose code equals the symbol.
// ----------------------------------------------------------------------------
module mme_match #(
    parameter int MAX_SYMBOLS = 8,
    parameter int SLW         = 3
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [SLW-1:0]                 i_wr_slot,
    input  logic [mme_pkg::SYMBOL_W-1:0]   i_wr_code,
    input  logic [mme_pkg::CFG_DATA_W-1:0] i_count,
    input  logic [mme_pkg::SYMBOL_W-1:0]   i_symbol,
    output logic                           o_hit,
    output logic [SLW-1:0]                 o_slot
);
    import mme_pkg::*;

    logic [SYMBOL_W-1:0] r_codes [MAX_SYMBOLS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_codes[i_wr_slot] <= i_wr_code;
        end
    end

    // scan from the top so the lowest matching slot wins
    always_comb begin
        o_hit  = 1'b0;
        o_slot = '0;
        for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
            if (i < int'(i_count) && r_codes[i] == i_symbol) begin
                o_hit  = 1'b1;
                o_slot = SLW'(i);
            end
        end
    end

endmodule

[rtl/moore_machine_engine_top.sv]
// ----------------------------------------------------------------------------
// moore_machine_engine_top
// Programmable Moore machine: loads alphabet codes, a next-state memory and
// a state-output memory, then walks word symbols through the machine.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake         | payload
//  i_in     | in  | valid / ready     | cmd, entry_state, entry_slot, entry_value, symbol
//  o_out    | out | valid / ready     | out_value, out_char, word_last
//  i_cfg    | in  | valid / ready (1) | index, data
//
//  One item per cycle while i_in.ready is high. A result goes through the
//  state-output memory read and then the output register. A matched symbol
//  reads the next state from the next-state memory; the following item uses
//  that read data directly. Stalls on o_out fill the read stage and the output
//  register before i_in drops ready. No clearing pass after reset; tables are
//  undefined until loaded.
// ----------------------------------------------------------------------------
module moore_machine_engine_top #(
    parameter int MAX_STATES  = 16,
    parameter int MAX_SYMBOLS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mme_in_if.sink    i_in,
    mme_out_if.source o_out,
    mme_cfg_if.sink   i_cfg
);
    import mme_pkg::*;

    `include "assert_macros.svh"

    localparam int SW       = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int SLW      = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int NS_DEPTH = MAX_STATES * MAX_SYMBOLS;
    localparam int ADW      = $clog2(NS_DEPTH);
    localparam int MOD_N    = 256;

    typedef logic [SW-1:0] t_mod_tab [MOD_N];

    function automatic t_mod_tab f_mod_tab();
        t_mod_tab tab;
        for (int i = 0; i < MOD_N; i++) begin
            tab[i] = SW'(i % MAX_STATES);
        end
        return tab;
    endfunction

    localparam t_mod_tab C_MOD_TAB = f_mod_tab();

    // configuration
    logic [CFG_DATA_W-1:0] r_sym_count;
    logic [CFG_DATA_W-1:0] r_start;

    // machine state and memories
    logic [SW-1:0]          r_cs;
    logic                   r_ns_pend;
    logic [SW-1:0]          r_ns_mem [NS_DEPTH];
    logic [SW-1:0]          r_ns_rdata;
    logic [OUT_VALUE_W-1:0] r_out_mem [MAX_STATES];
    logic [OUT_VALUE_W-1:0] r_out_rdata;

    // read stage and output register
    logic                   r_s1_vld;
    logic                   r_s1_last;
    logic                   r_o_vld;
    logic [OUT_VALUE_W-1:0] r_o_value;
    logic [OUT_CHAR_W-1:0]  r_o_char;
    logic                   r_o_last;

    logic                   n_s1_vld;
    logic                   n_o_vld;
    logic [SW-1:0]          n_cs;

    logic                   w_acc;
    logic                   w_ld_sym;
    logic                   w_ld_next;
    logic                   w_ld_out;
    logic                   w_feed;
    logic                   w_end;
    logic                   w_state_ok;
    logic                   w_slot_ok;
    logic                   w_hit;
    logic [SLW-1:0]         w_slot;
    logic                   w_feed_hit;
    logic                   w_emit;
    logic [SW-1:0]          w_cs;
    logic [SW-1:0]          w_start_idx;
    logic [SW-1:0]          w_est;
    logic [ADW-1:0]         w_ns_wr_addr;
    logic [ADW-1:0]         w_ns_rd_addr;
    logic                   w_s1_move;
    logic                   w_s1_adv;

    // ---------------------------------------------------------------- config
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_count <= SYMBOL_COUNT_RST;
            r_start     <= START_STATE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SYMBOL_COUNT: r_sym_count <= i_cfg.data;
                CFG_START_STATE:  r_start     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign w_start_idx = C_MOD_TAB[{{(VALUE_W - CFG_DATA_W){1'b0}}, r_start}];

    // ---------------------------------------------------------------- decode
    assign w_s1_move  = !r_o_vld || o_out.ready;
    assign w_s1_adv   = r_s1_vld && w_s1_move;
    assign i_in.ready = !r_s1_vld || w_s1_move;
    assign w_acc      = i_in.valid && i_in.ready;

    always_comb begin
        w_ld_sym  = 1'b0;
        w_ld_next = 1'b0;
        w_ld_out  = 1'b0;
        w_feed    = 1'b0;
        w_end     = 1'b0;
        case (i_in.cmd)
            CMD_LOAD_SYM:  w_ld_sym  = w_acc;
            CMD_LOAD_NEXT: w_ld_next = w_acc;
            CMD_LOAD_OUT:  w_ld_out  = w_acc;
            CMD_FEED:      w_feed    = w_acc;
            CMD_END_WORD:  w_end     = w_acc;
            default: ;
        endcase
    end

    assign w_state_ok = int'(i_in.entry_state) < MAX_STATES;
    assign w_slot_ok  = int'(i_in.entry_slot) < MAX_SYMBOLS;
    assign w_est      = SW'(i_in.entry_state);

    mme_match #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .SLW         (SLW)
    ) u_match (
        .i_clk     (i_clk),
        .i_wr_en   (w_ld_sym && w_slot_ok),
        .i_wr_slot (SLW'(i_in.entry_slot)),
        .i_wr_code (i_in.entry_value),
        .i_count   (r_sym_count),
        .i_symbol  (i_in.symbol),
        .o_hit     (w_hit),
        .o_slot    (w_slot)
    );

    assign w_feed_hit = w_feed && w_hit;
    assign w_emit     = w_feed_hit || w_end;

    // take the next state straight from the memory after a matched symbol
    assign w_cs = r_ns_pend ? r_ns_rdata : r_cs;

    // ---------------------------------------------------------------- next-state memory
    assign w_ns_wr_addr = ADW'(int'(i_in.entry_state) * MAX_SYMBOLS + int'(i_in.entry_slot));
    assign w_ns_rd_addr = ADW'(int'(w_cs) * MAX_SYMBOLS + int'(w_slot));

    always_ff @(posedge i_clk) begin
        if (w_ld_next && w_state_ok && w_slot_ok) begin
            r_ns_mem[w_ns_wr_addr] <= C_MOD_TAB[i_in.entry_value];
        end
        if (w_feed_hit) begin
            r_ns_rdata <= r_ns_mem[w_ns_rd_addr];
        end
    end

    // ---------------------------------------------------------------- state-output memory
    always_ff @(posedge i_clk) begin
        if (w_ld_out && w_state_ok) begin
            r_out_mem[w_est] <= i_in.entry_value[OUT_VALUE_W-1:0];
        end
        if (w_emit) begin
            r_out_rdata <= r_out_mem[w_cs];
        end
    end

    // ---------------------------------------------------------------- current state
    assign n_cs = w_end ? w_start_idx : w_cs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs      <= '0;
            r_ns_pend <= 1'b0;
        end else begin
            r_cs      <= n_cs;
            r_ns_pend <= w_feed_hit;
        end
    end

    // ---------------------------------------------------------------- result path
    always_comb begin
        n_s1_vld = r_s1_vld;
        if (w_emit) begin
            n_s1_vld = 1'b1;
        end else if (w_s1_adv) begin
            n_s1_vld = 1'b0;
        end
        n_o_vld = r_o_vld;
        if (w_s1_adv) begin
            n_o_vld = 1'b1;
        end else if (o_out.ready) begin
            n_o_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_o_vld  <= n_o_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_s1_last <= w_end;
        end
        if (w_s1_adv) begin
            r_o_value <= r_out_rdata;
            r_o_char  <= OUT_CHAR_W'(r_out_rdata) + ASCII_ZERO;
            r_o_last  <= r_s1_last;
        end
    end

    assign o_out.valid     = r_o_vld;
    assign o_out.out_value = r_o_value;
    assign o_out.out_char  = r_o_char;
    assign o_out.word_last = r_o_last;

    // ---------------------------------------------------------------- checks
    `ASSERT_ALWAYS(a_stall_full, !i_in.ready |-> (r_s1_vld && r_o_vld), "input stalled with room")
    `ASSERT_NEXT(a_emit_lands, w_emit, r_s1_vld, "emitted item lost in read stage")
    `ASSERT_ALWAYS(a_pend_src, r_ns_pend |-> $past(w_feed_hit), "next-state read without a match")
    `ASSERT_ALWAYS(a_hit_slot, w_hit |-> (int'(w_slot) < int'(r_sym_count)), "match beyond count")

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for moore_machine_engine_top. A short table of
// directed items comes first, then phases of random items under different
// symbol_count and start_state settings, with random idle gaps and stalls on
// both channels. A behavioral copy of the machine tracks the table contents
// and the current state; each result is compared with it or with a typed row.
// ----------------------------------------------------------------------------
module tb;
    import mme_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 250;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int NUM_SLOTS    = 8;
    localparam int NUM_STATES   = 16;

    // Command and register codes that the block must ignore
    localparam logic [CMD_W-1:0]     CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_W-1:0]     CMD_UNUSED_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B  = 2'd3;

    // Gap modes for either side
    localparam int GAP_NONE   = 0;
    localparam int GAP_ALWAYS = 1;
    localparam int GAP_RARE   = 2;

    typedef struct {
        logic [CMD_W-1:0]       cmd;
        logic [STATE_FLD_W-1:0] est;
        logic [SLOT_FLD_W-1:0]  slot;
        logic [VALUE_W-1:0]     val;
        logic [SYMBOL_W-1:0]    sym;
    } t_cmd_item;

    typedef struct {
        logic [OUT_VALUE_W-1:0] value;
        logic [OUT_CHAR_W-1:0]  chr;
        logic                   last;
    } t_emit;

    typedef struct {
        t_cmd_item item;
        bit        typed;
        t_emit     res;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    mme_in_if  in_if();
    mme_out_if out_if();
    mme_cfg_if cfg_if();

    moore_machine_engine_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Shadow machine
    logic [SYMBOL_W-1:0]    sym_codes [NUM_SLOTS];
    bit                     sym_ok    [NUM_SLOTS];
    logic [STATE_FLD_W-1:0] next_tab  [NUM_STATES*NUM_SLOTS];
    bit                     next_ok   [NUM_STATES*NUM_SLOTS];
    logic [OUT_VALUE_W-1:0] out_tab   [NUM_STATES];
    bit                     out_ok    [NUM_STATES];
    logic [STATE_FLD_W-1:0] cur_state;
    logic [CFG_DATA_W-1:0]  cfg_count;
    logic [CFG_DATA_W-1:0]  cfg_start;

    t_emit    pending_q[$];
    t_emit    got_exp;
    t_dir_row dir_q[$];
    int       errors;
    int       cycles;
    int       sender_mode;
    int       recv_mode;
    bit       hold_req;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    function automatic int draw_gap(int mode);
        case (mode)
            GAP_ALWAYS: return $urandom_range(0, 15);
            GAP_RARE:   return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 15) : 0;
            default:    return 0;
        endcase
    endfunction

    function automatic int live_slots();
        return (cfg_count > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_count);
    endfunction

    function automatic t_emit state_emit(logic last);
        t_emit r;
        r.value = out_tab[cur_state];
        r.chr   = OUT_CHAR_W'(out_tab[cur_state]) + ASCII_ZERO;
        r.last  = last;
        return r;
    endfunction

    // Lowest live slot whose code equals the symbol, or -1
    function automatic int match_slot(logic [SYMBOL_W-1:0] sym);
        int n;
        n = live_slots();
        for (int i = 0; i < n; i++) begin
            if (sym_codes[i] == sym) return i;
        end
        return -1;
    endfunction

    // Advance the shadow machine by one accepted item
    function automatic bit machine_step(t_cmd_item it, output t_emit r);
        int m;
        r = '{default: '0};
        case (it.cmd)
            CMD_LOAD_SYM: begin
                sym_codes[it.slot] = it.val;
                sym_ok[it.slot]    = 1'b1;
            end
            CMD_LOAD_NEXT: begin
                next_tab[{it.est, it.slot}] = it.val[STATE_FLD_W-1:0];
                next_ok[{it.est, it.slot}]  = 1'b1;
            end
            CMD_LOAD_OUT: begin
                out_tab[it.est] = it.val[OUT_VALUE_W-1:0];
                out_ok[it.est]  = 1'b1;
            end
            CMD_FEED: begin
                m = match_slot(it.sym);
                if (m >= 0) begin
                    r = state_emit(1'b0);
                    cur_state = next_tab[{cur_state, SLOT_FLD_W'(m)}];
                    return 1'b1;
                end
            end
            CMD_END_WORD: begin
                r = state_emit(1'b1);
                cur_state = cfg_start;
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic logic [SYMBOL_W-1:0] rand_code();
        return ($urandom_range(0, 1) == 1) ? SYMBOL_W'($urandom_range(0, 15))
                                           : SYMBOL_W'($urandom_range(0, 255));
    endfunction

    // Replace an item that would read a never-written table entry by the
    // load that fills that entry
    function automatic bit fill_gap(t_cmd_item it, output t_cmd_item fill);
        int n;
        int m;
        fill      = it;
        fill.est  = cur_state;
        fill.val  = VALUE_W'($urandom_range(0, 255));
        if (it.cmd == CMD_FEED) begin
            n = live_slots();
            for (int i = 0; i < n; i++) begin
                if (!sym_ok[i]) begin
                    fill.cmd  = CMD_LOAD_SYM;
                    fill.slot = SLOT_FLD_W'(i);
                    fill.val  = rand_code();
                    return 1'b1;
                end
            end
            m = match_slot(it.sym);
            if (m < 0) return 1'b0;
            if (!out_ok[cur_state]) begin
                fill.cmd = CMD_LOAD_OUT;
                return 1'b1;
            end
            if (!next_ok[{cur_state, SLOT_FLD_W'(m)}]) begin
                fill.cmd  = CMD_LOAD_NEXT;
                fill.slot = SLOT_FLD_W'(m);
                return 1'b1;
            end
        end else if (it.cmd == CMD_END_WORD && !out_ok[cur_state]) begin
            fill.cmd = CMD_LOAD_OUT;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_cmd_item make_item();
        t_cmd_item it;
        t_cmd_item fill;
        int        pick;
        int        n;
        it.cmd  = CMD_FEED;
        it.est  = STATE_FLD_W'($urandom_range(0, 15));
        it.slot = SLOT_FLD_W'($urandom_range(0, 7));
        it.val  = VALUE_W'($urandom_range(0, 255));
        it.sym  = SYMBOL_W'($urandom_range(0, 255));
        pick    = $urandom_range(0, 99);
        n       = live_slots();
        if (pick < 50) begin
            // symbol taken from the live alphabet
            if (n > 0) it.sym = sym_codes[$urandom_range(0, n - 1)];
        end else if (pick < 62) begin
            it.cmd = CMD_END_WORD;
        end else if (pick < 70) begin
            it.sym = rand_code();
        end else if (pick < 75) begin
            it.cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        end else begin
            it.cmd = CMD_W'($urandom_range(CMD_LOAD_SYM, CMD_LOAD_OUT));
            if (it.cmd == CMD_LOAD_SYM) it.val = rand_code();
        end
        if (fill_gap(it, fill)) it = fill;
        return it;
    endfunction

    function automatic t_dir_row mk_row(logic [CMD_W-1:0] cmd, logic [STATE_FLD_W-1:0] est,
                                        logic [SLOT_FLD_W-1:0] slot, logic [VALUE_W-1:0] val,
                                        logic [SYMBOL_W-1:0] sym, bit typed,
                                        logic [OUT_VALUE_W-1:0] ov, logic [OUT_CHAR_W-1:0] oc,
                                        logic lst);
        t_dir_row r;
        r.item = '{cmd: cmd, est: est, slot: slot, val: val, sym: sym};
        r.typed = typed;
        r.res   = '{value: ov, chr: oc, last: lst};
        return r;
    endfunction

    // Starts and ends at a falling edge
    task automatic send_item(input t_cmd_item it, input bit typed, input t_emit typed_res);
        int    w;
        bit    got;
        t_emit r;
        w = draw_gap(sender_mode);
        if (w > 0) begin
            in_if.valid <= 1'b0;
            repeat (w) @(negedge i_clk);
        end
        in_if.cmd         <= it.cmd;
        in_if.entry_state <= it.est;
        in_if.entry_slot  <= it.slot;
        in_if.entry_value <= it.val;
        in_if.symbol      <= it.sym;
        in_if.valid       <= 1'b1;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        got = machine_step(it, r);
        if (got) pending_q.push_back(typed ? typed_res : r);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every result is back and the pipe is empty
    task automatic quiesce(int extra);
        in_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        if (idx == CFG_SYMBOL_COUNT) cfg_count = data;
        else if (idx == CFG_START_STATE) cfg_start = data;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Result sink: per-item stall, one long hold-off on request
    initial begin
        int w;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            w = draw_gap(recv_mode);
            if (hold_req) begin
                w = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (w > 0) begin
                out_if.ready <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_q.size() == 0) begin
                report($sformatf("result with nothing pending: value %0d char %0d last %0b",
                                 out_if.out_value, out_if.out_char, out_if.word_last));
            end else begin
                got_exp = pending_q.pop_front();
                if (out_if.out_value !== got_exp.value)
                    report($sformatf("out_value %0d, predicted %0d",
                                     out_if.out_value, got_exp.value));
                if (out_if.out_char !== got_exp.chr)
                    report($sformatf("out_char %0d, predicted %0d",
                                     out_if.out_char, got_exp.chr));
                if (out_if.word_last !== got_exp.last)
                    report($sformatf("word_last %0b, predicted %0b",
                                     out_if.word_last, got_exp.last));
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int        done;
        bit        paused;
        t_cmd_item it;
        t_emit     none;

        none              = '{default: '0};
        errors            = 0;
        hold_req          = 1'b0;
        sender_mode       = GAP_ALWAYS;
        recv_mode         = GAP_ALWAYS;
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.cmd         = '0;
        in_if.entry_state = '0;
        in_if.entry_slot  = '0;
        in_if.entry_value = '0;
        in_if.symbol      = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = '0;
        cfg_if.data       = '0;

        for (int i = 0; i < NUM_SLOTS; i++) sym_ok[i] = 1'b0;
        for (int i = 0; i < NUM_STATES*NUM_SLOTS; i++) next_ok[i] = 1'b0;
        for (int i = 0; i < NUM_STATES; i++) out_ok[i] = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) sym_codes[i] = '0;
        cfg_count = SYMBOL_COUNT_RST;
        cfg_start = START_STATE_RST;
        cur_state = START_STATE_RST;

        // cmd, state, slot, value, symbol, typed, out_value, out_char, last
        dir_q.push_back(mk_row(CMD_LOAD_OUT,  4'd0,  3'd0, 8'hFF, 8'h00, 0, 0, 0, 0));
        dir_q.push_back(mk_row(CMD_END_WORD,  4'd0,  3'd0, 8'h00, 8'h00, 1, 15, 8'd63, 1));
        dir_q.push_back(mk_row(CMD_LOAD_OUT,  4'd0,  3'd0, 8'h00, 8'h00, 0, 0, 0, 0));
        dir_q.push_back(mk_row(CMD_END_WORD,  4'd0,  3'd0, 8'h00, 8'h00, 1, 0, 8'd48, 1));
        dir_q.push_back(mk_row(CMD_LOAD_SYM,  4'd0,  3'd0, 8'h00, 8'h00, 0, 0, 0, 0));
        dir_q.push_back(mk_row(CMD_LOAD_SYM,  4'd0,  3'd1, 8'hFF, 8'h00, 0, 0, 0, 0));
        dir_q.push_back(mk_row(CMD_LOAD_SYM,  4'd0,  3'd2, 8'h30, 8'h00, 0, 0, 0, 0));
        dir_q.push_back(mk_row(CMD_LOAD_SYM,  4'd0,  3'd3, 8'h41, 8'h00, 0, 0, 0, 0));
        dir_q.push_back(mk_row(CMD_LOAD_SYM,  4'd0,  3'd4, 8'h42, 8'h00, 0, 0, 0, 0));
        // duplicate codes: the lower slot must win
        dir_q.push_back(mk_row(CMD_LOAD_SYM,  4'd0,  3'd5, 8'h41, 8'h00, 0, 0, 0, 0));
        dir_q.push_back(mk_row(CMD_LOAD_SYM,  4'd0,  3'd6, 8'h7F, 8'h00, 0, 0, 0, 0));
        dir_q.push_back(mk_row(CMD_LOAD_SYM,  4'd15, 3'd7, 8'hFF, 8'h00, 0, 0, 0, 0));
        // next state wider than the table wraps
        dir_q.push_back(mk_row(CMD_LOAD_NEXT, 4'd0,  3'd0, 8'hFF, 8'h00, 0, 0, 0, 0));
        dir_q.push_back(mk_row(CMD_LOAD_OUT,  4'd15, 3'd0, 8'h09, 8'h00, 0, 0, 0, 0));
        dir_q.push_back(mk_row(CMD_FEED,      4'd0,  3'd0, 8'h00, 8'h00, 1, 0, 8'd48, 0));
        dir_q.push_back(mk_row(CMD_END_WORD,  4'd0,  3'd0, 8'h00, 8'h00, 1, 9, 8'd57, 1));
        dir_q.push_back(mk_row(CMD_LOAD_NEXT, 4'd0,  3'd3, 8'h23, 8'h00, 0, 0, 0, 0));
        dir_q.push_back(mk_row(CMD_LOAD_OUT,  4'd3,  3'd0, 8'hA5, 8'h00, 0, 0, 0, 0));
        dir_q.push_back(mk_row(CMD_FEED,      4'd0,  3'd0, 8'h00, 8'h41, 0, 0, 0, 0));
        // unmatched symbol and unknown commands leave no trace
        dir_q.push_back(mk_row(CMD_FEED,      4'd0,  3'd0, 8'h00, 8'h80, 0, 0, 0, 0));
        dir_q.push_back(mk_row(CMD_UNUSED_LO, 4'd0,  3'd0, 8'h00, 8'h00, 0, 0, 0, 0));
        dir_q.push_back(mk_row(CMD_UNUSED_HI, 4'd15, 3'd7, 8'hFF, 8'hFF, 0, 0, 0, 0));
        dir_q.push_back(mk_row(CMD_LOAD_NEXT, 4'd3,  3'd1, 8'h0F, 8'h00, 0, 0, 0, 0));
        dir_q.push_back(mk_row(CMD_FEED,      4'd0,  3'd0, 8'h00, 8'hFF, 0, 0, 0, 0));
        dir_q.push_back(mk_row(CMD_END_WORD,  4'd0,  3'd0, 8'h00, 8'h00, 1, 9, 8'd57, 1));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_q[k]) send_item(dir_q[k].item, dir_q[k].typed, dir_q[k].res);
        quiesce(DRAIN_CYCLES);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    cfg_write(CFG_SYMBOL_COUNT, 4'd8);
                    cfg_write(CFG_START_STATE, 4'd0);
                end
                1: begin
                    cfg_write(CFG_SYMBOL_COUNT, 4'd1);
                    cfg_write(CFG_START_STATE, 4'd15);
                end
                2: begin
                    cfg_write(CFG_SYMBOL_COUNT, 4'd0);
                    cfg_write(CFG_START_STATE, 4'd5);
                end
                3: begin
                    cfg_write(CFG_SYMBOL_COUNT, 4'd15);
                    cfg_write(CFG_START_STATE, CFG_DATA_W'($urandom_range(0, 15)));
                end
                4: begin
                    cfg_write(CFG_UNUSED_A, CFG_DATA_W'($urandom_range(0, 15)));
                    cfg_write(CFG_UNUSED_B, CFG_DATA_W'($urandom_range(0, 15)));
                    cfg_write(CFG_SYMBOL_COUNT, CFG_DATA_W'($urandom_range(1, 8)));
                    cfg_write(CFG_START_STATE, CFG_DATA_W'($urandom_range(0, 15)));
                end
                default: begin
                    cfg_write(CFG_SYMBOL_COUNT, ($urandom_range(0, 3) == 0)
                                                ? CFG_DATA_W'($urandom_range(0, 15))
                                                : CFG_DATA_W'($urandom_range(1, 8)));
                    cfg_write(CFG_START_STATE, CFG_DATA_W'($urandom_range(0, 15)));
                end
            endcase

            case (p)
                0: begin
                    sender_mode = GAP_NONE;
                    recv_mode   = GAP_NONE;
                end
                1: begin
                    // keep offering items while the sink holds off
                    sender_mode = GAP_NONE;
                    recv_mode   = GAP_ALWAYS;
                    hold_req    = 1'b1;
                end
                default: begin
                    sender_mode = $urandom_range(GAP_NONE, GAP_RARE);
                    recv_mode   = $urandom_range(GAP_NONE, GAP_RARE);
                end
            endcase

            done   = 0;
            paused = 1'b0;
            while (done < PHASE_ITEMS) begin
                if (p == 3 && !paused && done >= PHASE_ITEMS / 2) begin
                    quiesce(0);
                    paused = 1'b1;
                end
                it = make_item();
                send_item(it, 1'b0, none);
                done++;
            end
            quiesce(DRAIN_CYCLES);
        end

        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
